FILE: src/rau_pkg.sv
package rau_pkg;

  // Width of the operand and result values; the port fields are always FIELD_W wide.
  localparam int WIDTH   = 32;
  localparam int FIELD_W = 32;

  // Raw products and sums are twice the value width.
  localparam int PW    = 2 * WIDTH;
  // The shared adder is one bit wider so it can take a shifted division remainder.
  localparam int UW    = PW + 1;
  localparam int CNT_W = $clog2(PW);
  localparam int K_W   = $clog2(PW);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

  // Largest magnitude that a negative result may have; a positive one must stay below it.
  localparam logic [PW-1:0] NUM_LIM = PW'(1) << (WIDTH - 1);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIVZ = 2'd1,
    STAT_OVFL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_COMB2,
    S_GINIT,
    S_GCD,
    S_SHIFT,
    S_DIVN,
    S_DIVD,
    S_FINISH
  } state_t;

endpackage

FILE: src/rational_arithmetic_unit_top.sv
// Channel | Direction | Ports                                              | Handshake
// input   | in        | in_mode, in_a_num, in_a_den, in_b_num, in_b_den    | in_valid / in_stall
// result  | out       | out_res_num, out_res_den, out_status               | out_valid / out_stall
//
// On an error path a word goes from acceptance straight to S_FINISH and the output register.
// Otherwise it takes up to 3 products on the shared 32x32 multiplier, up to 2 add/subtract
// steps, binary GCD steps (swaps included) on the shared subtractor, two restoring divisions
// (skipped when the odd part of the GCD is 1), and the load. in_stall is high from acceptance
// until that load; a result held by out_stall delays it. The next word can be taken while a
// loaded result waits in the output register. Reset is synchronous, active low; it clears state, out_valid.
module rational_arithmetic_unit_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_a_num,
  input  logic [rau_pkg::FIELD_W-1:0]   in_a_den,
  input  logic signed [rau_pkg::FIELD_W-1:0] in_b_num,
  input  logic [rau_pkg::FIELD_W-1:0]   in_b_den,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rau_pkg::FIELD_W-1:0] out_res_num,
  output logic [rau_pkg::FIELD_W-1:0]   out_res_den,
  output logic [1:0]                    out_status
);

  import rau_pkg::*;

  // Sequencer and operand registers.
  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic                an_r, an_nxt;
  logic                bn_r, bn_nxt;
  logic                rneg_r, rneg_nxt;
  logic [WIDTH-1:0]    am_r, am_nxt;
  logic [WIDTH-1:0]    bm_r, bm_nxt;
  logic [WIDTH-1:0]    ad_r, ad_nxt;
  logic [WIDTH-1:0]    bd_r, bd_nxt;
  logic [PW-1:0]       num_r, num_nxt;
  logic [PW-1:0]       t2_r, t2_nxt;
  logic [PW-1:0]       den_r, den_nxt;
  logic [PW-1:0]       x_r, x_nxt;
  logic [PW-1:0]       y_r, y_nxt;
  logic [PW-1:0]       rem_r, rem_nxt;
  logic [PW-1:0]       dq_r, dq_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  status_t             st_r, st_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]  out_num_r, out_num_nxt;
  logic [FIELD_W-1:0]  out_den_r, out_den_nxt;
  status_t             out_st_r, out_st_nxt;

  // Input fields cut to the value width.
  logic [WIDTH-1:0]    a_v, b_v;

  // Shared multiplier and shared adder/subtractor.
  logic [WIDTH-1:0]    mul_a, mul_b;
  logic [PW-1:0]       mul_p;
  logic [UW-1:0]       alu_a, alu_b;
  logic                alu_sub;
  logic [UW:0]         alu_sum;
  logic                alu_nb;

  logic                s2;
  logic                ovf;
  logic                load;
  logic [PW-1:0]       quot;

  assign a_v = in_a_num[WIDTH-1:0];
  assign b_v = in_b_num[WIDTH-1:0];

  assign mul_p   = mul_a * mul_b;
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (UW + 1)'(alu_sub);
  // With subtraction, a carry out means no borrow.
  assign alu_nb  = alu_sum[UW];

  // Effective sign of the second operand for add and subtract.
  assign s2 = (mode_r == MODE_SUB) ? !bn_r : bn_r;

  // Next quotient word of a division step.
  assign quot = {dq_r[PW-2:0], alu_nb};

  // The reduced result must fit a signed numerator and an unsigned denominator.
  assign ovf = (|den_r[PW-1:WIDTH]) || (rneg_r ? (num_r > NUM_LIM) : (num_r >= NUM_LIM));

  assign load = !out_valid_r || !out_stall;

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r    <= mode_nxt;
    an_r      <= an_nxt;
    bn_r      <= bn_nxt;
    rneg_r    <= rneg_nxt;
    am_r      <= am_nxt;
    bm_r      <= bm_nxt;
    ad_r      <= ad_nxt;
    bd_r      <= bd_nxt;
    num_r     <= num_nxt;
    t2_r      <= t2_nxt;
    den_r     <= den_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    rem_r     <= rem_nxt;
    dq_r      <= dq_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    st_r      <= st_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_st_r  <= out_st_nxt;
  end

  // Sequencer: next state, operand selection for the shared units, register updates.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    an_nxt      = an_r;
    bn_nxt      = bn_r;
    rneg_nxt    = rneg_r;
    am_nxt      = am_r;
    bm_nxt      = bm_r;
    ad_nxt      = ad_r;
    bd_nxt      = bd_r;
    num_nxt     = num_r;
    t2_nxt      = t2_r;
    den_nxt     = den_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    rem_nxt     = rem_r;
    dq_nxt      = dq_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    st_nxt      = st_r;
    out_num_nxt = out_num_r;
    out_den_nxt = out_den_r;
    out_st_nxt  = out_st_r;
    out_valid_nxt = out_valid_r && out_stall;

    // Default unit operands: GCD compare and subtract.
    mul_a   = ad_r;
    mul_b   = (mode_r == MODE_DIV) ? bm_r : bd_r;
    alu_a   = {1'b0, x_r};
    alu_b   = {1'b0, y_r};
    alu_sub = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Take the word apart into signs and magnitudes.
          mode_nxt = mode_t'(in_mode);
          an_nxt   = a_v[WIDTH-1];
          bn_nxt   = b_v[WIDTH-1];
          am_nxt   = a_v[WIDTH-1] ? (~a_v + WIDTH'(1)) : a_v;
          bm_nxt   = b_v[WIDTH-1] ? (~b_v + WIDTH'(1)) : b_v;
          ad_nxt   = in_a_den[WIDTH-1:0];
          bd_nxt   = in_b_den[WIDTH-1:0];
          st_nxt   = STAT_OK;
          if ((in_a_den[WIDTH-1:0] == '0) || (in_b_den[WIDTH-1:0] == '0) ||
              ((mode_t'(in_mode) == MODE_DIV) && (b_v == '0))) begin
            st_nxt    = STAT_DIVZ;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_MUL0;
          end
        end
      end

      // First product: the numerator, or the first cross term of a sum.
      S_MUL0: begin
        mul_a    = am_r;
        mul_b    = (mode_r == MODE_MUL) ? bm_r : bd_r;
        num_nxt  = mul_p;
        rneg_nxt = an_r ^ bn_r;
        if ((mode_r == MODE_ADD) || (mode_r == MODE_SUB)) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_MUL2;
        end
      end

      // Second cross term of a sum or difference.
      S_MUL1: begin
        mul_a     = bm_r;
        mul_b     = ad_r;
        t2_nxt    = mul_p;
        state_nxt = S_MUL2;
      end

      // Denominator product.
      S_MUL2: begin
        den_nxt = mul_p;
        if ((mode_r == MODE_ADD) || (mode_r == MODE_SUB)) begin
          state_nxt = S_COMB;
        end else begin
          state_nxt = S_GINIT;
        end
      end

      // Combine the cross terms in sign-magnitude form.
      S_COMB: begin
        alu_a   = {1'b0, num_r};
        alu_b   = {1'b0, t2_r};
        alu_sub = (an_r != s2);
        if (!alu_sub || alu_nb) begin
          num_nxt   = alu_sum[PW-1:0];
          rneg_nxt  = an_r;
          state_nxt = S_GINIT;
        end else begin
          state_nxt = S_COMB2;
        end
      end

      // The second term was larger: take the difference the other way round.
      S_COMB2: begin
        alu_a     = {1'b0, t2_r};
        alu_b     = {1'b0, num_r};
        num_nxt   = alu_sum[PW-1:0];
        rneg_nxt  = s2;
        state_nxt = S_GINIT;
      end

      // A zero numerator needs no reduction and comes out as 0/1.
      S_GINIT: begin
        if (num_r == '0) begin
          den_nxt   = PW'(1);
          rneg_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          x_nxt     = num_r;
          y_nxt     = den_r;
          k_nxt     = '0;
          state_nxt = S_GCD;
        end
      end

      // Binary GCD, one step per cycle; k counts the common factors of two.
      S_GCD: begin
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (alu_sum[PW-1:0] == '0) begin
          state_nxt = S_SHIFT;
        end else if (!alu_nb) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = alu_sum[PW-1:0] >> 1;
        end
      end

      // Remove the power of two of the GCD; the odd part is divided out next.
      S_SHIFT: begin
        dq_nxt  = num_r >> k_r;
        den_nxt = den_r >> k_r;
        rem_nxt = '0;
        cnt_nxt = '0;
        if (x_r == PW'(1)) begin
          num_nxt   = num_r >> k_r;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DIVN;
        end
      end

      // Restoring division of the numerator, then of the denominator.
      S_DIVN, S_DIVD: begin
        alu_a   = {rem_r, dq_r[PW-1]};
        alu_b   = {1'b0, x_r};
        dq_nxt  = quot;
        rem_nxt = alu_nb ? alu_sum[PW-1:0] : {rem_r[PW-2:0], dq_r[PW-1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt = '0;
          if (state_r == S_DIVN) begin
            num_nxt   = quot;
            dq_nxt    = den_r;
            rem_nxt   = '0;
            state_nxt = S_DIVD;
          end else begin
            den_nxt   = quot;
            state_nxt = S_FINISH;
          end
        end
      end

      // Range check and load of the output register once it is free.
      S_FINISH: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (st_r != STAT_OK) begin
            out_num_nxt = '0;
            out_den_nxt = FIELD_W'(1);
            out_st_nxt  = st_r;
          end else if (ovf) begin
            out_num_nxt = '0;
            out_den_nxt = FIELD_W'(1);
            out_st_nxt  = STAT_OVFL;
          end else begin
            out_num_nxt = rneg_r ? (-FIELD_W'(num_r[WIDTH-1:0])) : FIELD_W'(num_r[WIDTH-1:0]);
            out_den_nxt = FIELD_W'(den_r[WIDTH-1:0]);
            out_st_nxt  = STAT_OK;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_status  = out_st_r;

endmodule

FILE: src/rau_checker.sv
module rau_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [rau_pkg::FIELD_W-1:0] out_res_num,
  input logic [rau_pkg::FIELD_W-1:0]   out_res_den,
  input logic [1:0]                    out_status
);

  import rau_pkg::*;

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_num) &&
      $stable(out_res_den) && $stable(out_status))
    else $error("stalled result word changed");

  // The unit is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // An error result is always 0/1.
  a_error_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_res_num == '0) && (out_res_den == FIELD_W'(1)))
    else $error("error result is not 0/1");

  // No result word has a zero denominator, and the status code is a known one.
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res_den != '0) &&
      (out_status == STAT_OK || out_status == STAT_DIVZ || out_status == STAT_OVFL))
    else $error("result word has a zero denominator or a bad status");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (.*);

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  // Masks for the value width used by the block.
  localparam logic [63:0] VAL_MASK = (64'd1 << WIDTH) - 64'd1;
  localparam logic [63:0] SIGN_MAG = 64'd1 << (WIDTH - 1);

  // Handy operand values.
  localparam logic [FIELD_W-1:0] NUM_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] NUM_MIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] NEG_ONE = 32'hffff_ffff;
  localparam logic [FIELD_W-1:0] DEN_MAX = 32'hffff_ffff;

  // Cycles with no word accepted on either side before the run is abandoned.
  localparam int unsigned HANG_LIMIT = 20000;
  localparam int unsigned RANDOM_WORDS = 1000;

  typedef struct {
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    status_t            st;
  } ratio_t;

  // Predicts the reduced fraction for each accepted word and checks the results in order.
  class ratio_board;
    ratio_t      expected_ratios[$];
    int unsigned errors;

    function void split_value(input logic [FIELD_W-1:0] raw, output logic neg,
                              output logic [63:0] mag);
      logic [63:0] v;
      v = 64'(raw) & VAL_MASK;
      neg = (v & SIGN_MAG) != 0;
      if (neg) begin
        mag = (~v + 64'd1) & VAL_MASK;
        if (mag == 0) mag = SIGN_MAG;
      end else begin
        mag = v;
      end
    endfunction

    function logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
      logic [63:0] rem;
      while (y != 0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      return x;
    endfunction

    function ratio_t reduce_ratio(mode_t op, logic [FIELD_W-1:0] a_num,
                                  logic [FIELD_W-1:0] a_den, logic [FIELD_W-1:0] b_num,
                                  logic [FIELD_W-1:0] b_den);
      ratio_t      r;
      logic        a_neg, b_neg, b_eff_neg, r_neg;
      logic [63:0] am, bm, ad, bd, t1, t2, num, den, g;
      r.num = '0;
      r.den = 1;
      r.st  = STAT_OK;
      split_value(a_num, a_neg, am);
      split_value(b_num, b_neg, bm);
      ad = 64'(a_den) & VAL_MASK;
      bd = 64'(b_den) & VAL_MASK;
      if (ad == 0 || bd == 0) begin
        r.st = STAT_DIVZ;
        return r;
      end
      case (op)
        MODE_ADD, MODE_SUB: begin
          // Cross-multiply, then add or subtract the magnitudes by sign.
          t1 = am * bd;
          t2 = bm * ad;
          b_eff_neg = (op == MODE_SUB) ? !b_neg : b_neg;
          if (a_neg == b_eff_neg) begin
            num = t1 + t2;
            r_neg = a_neg;
          end else if (t1 >= t2) begin
            num = t1 - t2;
            r_neg = a_neg;
          end else begin
            num = t2 - t1;
            r_neg = b_eff_neg;
          end
          den = ad * bd;
        end
        MODE_MUL: begin
          num = am * bm;
          den = ad * bd;
          r_neg = a_neg != b_neg;
        end
        default: begin
          if (bm == 0) begin
            r.st = STAT_DIVZ;
            return r;
          end
          num = am * bd;
          den = ad * bm;
          r_neg = a_neg != b_neg;
        end
      endcase
      // A zero result is always 0/1.
      if (num == 0) return r;
      g = common_divisor(num, den);
      num = num / g;
      den = den / g;
      if (den > VAL_MASK || (r_neg ? num > SIGN_MAG : num > SIGN_MAG - 64'd1)) begin
        r.st = STAT_OVFL;
        return r;
      end
      r.num = FIELD_W'(r_neg ? (~num + 64'd1) : num);
      r.den = FIELD_W'(den);
      return r;
    endfunction

    function void note_word(mode_t op, logic [FIELD_W-1:0] a_num, logic [FIELD_W-1:0] a_den,
                            logic [FIELD_W-1:0] b_num, logic [FIELD_W-1:0] b_den);
      expected_ratios.push_back(reduce_ratio(op, a_num, a_den, b_num, b_den));
    endfunction

    function void check_word(logic [FIELD_W-1:0] num, logic [FIELD_W-1:0] den,
                             logic [1:0] st);
      ratio_t want;
      if (expected_ratios.size() == 0) begin
        $error("unexpected result word %0d/%0d status %0d", $signed(num), den, st);
        errors++;
        return;
      end
      want = expected_ratios.pop_front();
      if (num !== want.num) begin
        $error("res_num mismatch: expected %0d, got %0d", $signed(want.num), $signed(num));
        errors++;
      end
      if (den !== want.den) begin
        $error("res_den mismatch: expected %0d, got %0d", want.den, den);
        errors++;
      end
      if (st !== want.st) begin
        $error("status mismatch: expected %0d, got %0d", want.st, st);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_ratios.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_mode = '0;
  logic signed [FIELD_W-1:0] in_a_num = '0;
  logic [FIELD_W-1:0]        in_a_den = '0;
  logic signed [FIELD_W-1:0] in_b_num = '0;
  logic [FIELD_W-1:0]        in_b_den = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FIELD_W-1:0] out_res_num;
  logic [FIELD_W-1:0]        out_res_den;
  logic [1:0]                out_status;

  ratio_board  sb;
  int unsigned idle_cycles = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_pick;

  rational_arithmetic_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res_num(out_res_num),
    .out_res_den(out_res_den),
    .out_status (out_status)
  );

  always #1 clk = ~clk;

  // Result side stall: mostly short bursts, some long stalls and long open stretches.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 3);
      end else if (stall_pick < 80) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else if (stall_pick < 93) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(20, 300);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 60);
      end
    end
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_res_num, out_res_den, out_status);
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 350);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_num();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = int'($urandom_range(0, 100)) - 50;
      return FIELD_W'(v);
    end
    if (r < 60) begin
      v = int'($urandom_range(0, 200000)) - 100000;
      return FIELD_W'(v);
    end
    if (r < 78) return $urandom;
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return 1;
        2: return NEG_ONE;
        3: return NUM_MAX;
        default: return NUM_MIN;
      endcase
    end
    // Values with many factors of two, so reduction has work to do.
    v = (int'($urandom_range(0, 30)) - 15) << $urandom_range(0, 26);
    return FIELD_W'(v);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_den();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(1, 60);
    if (r < 65) return $urandom_range(1, 100000);
    if (r < 80) return $urandom;
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0: return 1;
        1: return 2;
        2: return DEN_MAX;
        default: return 32'h8000_0000;
      endcase
    end
    if (r < 96) return FIELD_W'(64'd1 << $urandom_range(0, 31));
    return '0;
  endfunction

  // Present one word after an optional gap and hold it until the block takes it.
  task automatic send_word(mode_t op, logic [FIELD_W-1:0] a_num, logic [FIELD_W-1:0] a_den,
                           logic [FIELD_W-1:0] b_num, logic [FIELD_W-1:0] b_den);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= op;
    in_a_num <= a_num;
    in_a_den <= a_den;
    in_b_num <= b_num;
    in_b_den <= b_den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, a_num, a_den, b_num, b_den);
  endtask

  // Stop sending and wait until every predicted result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: every operation, the field extremes and each error path.
    send_word(MODE_ADD, 1, 2, 1, 3);
    send_word(MODE_SUB, 1, 2, 1, 2);
    send_word(MODE_MUL, 0, 5, FIELD_W'(-3), 7);
    send_word(MODE_DIV, 3, 4, 0, 9);
    send_word(MODE_ADD, 1, 0, 1, 1);
    send_word(MODE_MUL, 1, 1, 1, 0);
    send_word(MODE_ADD, NUM_MAX, 1, NUM_MAX, 1);
    send_word(MODE_MUL, NUM_MIN, 1, NEG_ONE, 1);
    send_word(MODE_MUL, NUM_MIN, 1, 1, 1);
    send_word(MODE_DIV, NUM_MIN, 1, NEG_ONE, 1);
    send_word(MODE_SUB, 0, 1, NUM_MIN, 1);
    send_word(MODE_SUB, NUM_MIN, 1, 0, 1);
    send_word(MODE_MUL, 1, DEN_MAX, 1, 2);
    send_word(MODE_MUL, NEG_ONE, DEN_MAX, NEG_ONE, DEN_MAX);
    send_word(MODE_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
    send_word(MODE_DIV, FIELD_W'(-6), 4, FIELD_W'(-9), 2);
    send_word(MODE_SUB, NEG_ONE, 3, 2, 3);
    send_word(MODE_ADD, NEG_ONE, 32'h8000_0000, 1, 32'h8000_0000);
    send_word(MODE_DIV, 1, 1, NUM_MAX, 1);
    send_word(MODE_DIV, NUM_MAX, 1, NUM_MAX, DEN_MAX);
    send_word(MODE_MUL, NUM_MAX, NUM_MAX, NUM_MIN, 32'h8000_0000);
    send_word(MODE_DIV, NUM_MIN, 1, NUM_MIN, 1);
    send_word(MODE_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
    send_word(MODE_SUB, NUM_MAX, 1, NUM_MIN, 1);
    drain_results();

    // Random words, with one pause midway until the block has emptied.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain_results();
      send_word(mode_t'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(),
                pick_den());
    end
    drain_results();
    repeat (400) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
